@@ rtl/modem_response_line_parser_macros.svh @@
// assertion macros for the modem response line parser
// each macro expects clk and rst_n in scope at the point of use
`ifndef MODEM_RESPONSE_LINE_PARSER_MACROS_SVH
`define MODEM_RESPONSE_LINE_PARSER_MACROS_SVH

// same-cycle implication, off during reset
`define MRLP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mrlp assertion failed");

// next-cycle implication, off during reset
`define MRLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mrlp assertion failed");

`endif

@@ rtl/mrlp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlp_pkg
// Shared constants and types of the modem response line parser.
// ----------------------------------------------------------------------------
package mrlp_pkg;

    // line buffer size; a line closes when it reaches LINE_BUFFER-1 bytes
    localparam int LINE_BUFFER = 64;
    localparam int CNT_W       = $clog2(LINE_BUFFER);
    localparam int LINE_LAST   = LINE_BUFFER - 1;

    // characters of interest
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;

    // prefix lengths and time digit count
    localparam int RING_LEN    = 5;
    localparam int CARRIER_LEN = 10;
    localparam int TIME_DIGITS = 4;

    // link state codes
    typedef enum logic [1:0] {
        LINK_UNCONFIG = 2'd0,
        LINK_CONFIG   = 2'd1,
        LINK_LISTEN   = 2'd2,
        LINK_CONNECT  = 2'd3
    } link_t;

    // running state of the line being collected
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             cr_wait;
        logic             first_cr;
        logic             first_lf;
        logic             ring_match;
        logic             carrier_match;
        logic             star_seen;
        logic [2:0]       digits_taken;
        logic [3:0][3:0]  digits;
        logic             digits_ok;
    } line_t;

    localparam line_t LINE_CLEAR = '{
        count:         '0,
        cr_wait:       1'b0,
        first_cr:      1'b0,
        first_lf:      1'b0,
        ring_match:    1'b1,
        carrier_match: 1'b1,
        star_seen:     1'b0,
        digits_taken:  3'd0,
        digits:        '0,
        digits_ok:     1'b1
    };

    // decoded result of one completed line
    typedef struct packed {
        logic [5:0] line_length;
        logic       accept_call;
        logic       call_ended;
        logic       time_valid;
        logic [4:0] hours;
        logic [5:0] minutes;
        link_t      link_state;
    } result_t;

endpackage

@@ rtl/mrlp_channels.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlp channels
// Valid/ready channels of the parser: received bytes in, line reports out.
// ----------------------------------------------------------------------------
interface mrlp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mrlp_res_if;
    logic       valid;
    logic       ready;
    logic [5:0] line_length;
    logic       accept_call;
    logic       call_ended;
    logic       time_valid;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [1:0] link_state;

    modport source (
        output valid, output line_length, output accept_call, output call_ended,
        output time_valid, output hours, output minutes, output link_state,
        input ready
    );
    modport sink (
        input valid, input line_length, input accept_call, input call_ended,
        input time_valid, input hours, input minutes, input link_state,
        output ready
    );
endinterface

@@ rtl/mrlp_line_track.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlp_line_track
// Holds the state of the line being collected, adds one byte per step and
// flags when a line closes, handing over the line that closes.
// ----------------------------------------------------------------------------
module mrlp_line_track (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         rx_byte,
    output mrlp_pkg::line_t    fin_line,
    output logic               close
);

    mrlp_pkg::line_t line_reg;
    mrlp_pkg::line_t line_next;
    mrlp_pkg::line_t base;
    mrlp_pkg::line_t added;
    logic            close_first;
    logic            close_second;

    // prefix characters
    function automatic logic [7:0] ring_char(logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h52; // R
            3'd1:    c = 8'h49; // I
            3'd2:    c = 8'h4E; // N
            3'd3:    c = 8'h47; // G
            3'd4:    c = 8'h20; // space
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] carrier_char(logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h4E; // N
            4'd1:    c = 8'h4F; // O
            4'd2:    c = 8'h20; // space
            4'd3:    c = 8'h43; // C
            4'd4:    c = 8'h41; // A
            4'd5:    c = 8'h52; // R
            4'd6:    c = 8'h52; // R
            4'd7:    c = 8'h49; // I
            4'd8:    c = 8'h45; // E
            4'd9:    c = 8'h52; // R
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // one byte into the line state
    function automatic mrlp_pkg::line_t line_add(mrlp_pkg::line_t l, logic [7:0] b);
        mrlp_pkg::line_t n;
        n = l;
        if (l.count == '0)
        begin
            n.first_cr = (b == mrlp_pkg::CH_CR);
            n.first_lf = (b == mrlp_pkg::CH_LF);
        end
        if (l.count < mrlp_pkg::CNT_W'(mrlp_pkg::RING_LEN) && b != ring_char(l.count[2:0]))
        begin
            n.ring_match = 1'b0;
        end
        if (l.count < mrlp_pkg::CNT_W'(mrlp_pkg::CARRIER_LEN)
            && b != carrier_char(l.count[3:0]))
        begin
            n.carrier_match = 1'b0;
        end
        if (l.star_seen && l.digits_taken < 3'(mrlp_pkg::TIME_DIGITS))
        begin
            n.digits[l.digits_taken[1:0]] = b[3:0];
            if (b < mrlp_pkg::CH_0 || b > mrlp_pkg::CH_9)
            begin
                n.digits_ok = 1'b0;
            end
            n.digits_taken = l.digits_taken + 3'd1;
        end
        else if (!l.star_seen && b == mrlp_pkg::CH_STAR)
        begin
            n.star_seen    = 1'b1;
            n.digits_taken = 3'd0;
        end
        n.count   = l.count + mrlp_pkg::CNT_W'(1);
        n.cr_wait = (b == mrlp_pkg::CH_CR);
        return n;
    endfunction

    // a lone CR closes the old line before the new byte opens the next
    assign close_first  = line_reg.cr_wait && (rx_byte != mrlp_pkg::CH_LF);
    assign base         = close_first ? mrlp_pkg::LINE_CLEAR : line_reg;
    assign added        = line_add(base, rx_byte);

    // LF or a full buffer closes the line with this byte in it
    assign close_second = (rx_byte == mrlp_pkg::CH_LF)
                       || (added.count >= mrlp_pkg::CNT_W'(mrlp_pkg::LINE_LAST));

    assign fin_line  = close_first ? line_reg : added;
    assign close     = close_first || close_second;
    assign line_next = close_second ? mrlp_pkg::LINE_CLEAR : added;

    // line state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= mrlp_pkg::LINE_CLEAR;
        end
        else if (step)
        begin
            line_reg <= line_next;
        end
    end

endmodule

@@ rtl/mrlp_line_finish.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlp_line_finish
// Decodes a completed line: drop test, RING and NO CARRIER prefixes, time
// digits reduced to hours and minutes, and the new link state.
// ----------------------------------------------------------------------------
module mrlp_line_finish (
    input  mrlp_pkg::line_t   fin_line,
    input  logic              close,
    input  mrlp_pkg::link_t   link_cur,
    output logic              emit,
    output mrlp_pkg::link_t   link_next,
    output mrlp_pkg::result_t res
);

    logic [mrlp_pkg::CNT_W-1:0] len;
    logic                       drop;
    logic                       ring;
    logic                       nocar;
    logic                       tv;
    logic [7:0]                 hh_raw;
    logic [7:0]                 mm_raw;

    // two digits to hours, inputs up to 165
    function automatic logic [4:0] mod24(logic [7:0] v);
        logic [7:0] r;
        priority if (v >= 8'd144) r = v - 8'd144;
        else if (v >= 8'd120)     r = v - 8'd120;
        else if (v >= 8'd96)      r = v - 8'd96;
        else if (v >= 8'd72)      r = v - 8'd72;
        else if (v >= 8'd48)      r = v - 8'd48;
        else if (v >= 8'd24)      r = v - 8'd24;
        else                      r = v;
        return r[4:0];
    endfunction

    // two digits to minutes, inputs up to 165
    function automatic logic [5:0] mod60(logic [7:0] v);
        logic [7:0] r;
        priority if (v >= 8'd120) r = v - 8'd120;
        else if (v >= 8'd60)      r = v - 8'd60;
        else                      r = v;
        return r[5:0];
    endfunction

    assign len = fin_line.count;

    // bare CR, bare LF and CR LF lines are dropped
    assign drop = (len == mrlp_pkg::CNT_W'(1) && (fin_line.first_cr || fin_line.first_lf))
               || (len == mrlp_pkg::CNT_W'(2) && fin_line.first_cr);
    assign emit = close && !drop;

    // prefix and time decode
    assign ring  = fin_line.ring_match && len >= mrlp_pkg::CNT_W'(mrlp_pkg::RING_LEN);
    assign nocar = fin_line.carrier_match && len >= mrlp_pkg::CNT_W'(mrlp_pkg::CARRIER_LEN);
    assign tv    = fin_line.star_seen && fin_line.digits_ok
                && fin_line.digits_taken == 3'(mrlp_pkg::TIME_DIGITS);

    // tens times ten plus units, as shifts
    assign hh_raw = {1'b0, fin_line.digits[0], 3'b000} + {3'b000, fin_line.digits[0], 1'b0}
                  + {4'b0000, fin_line.digits[1]};
    assign mm_raw = {1'b0, fin_line.digits[2], 3'b000} + {3'b000, fin_line.digits[2], 1'b0}
                  + {4'b0000, fin_line.digits[3]};

    // NO CARRIER is applied after RING
    always_comb
    begin
        link_next = link_cur;
        if (emit && ring)
        begin
            link_next = mrlp_pkg::LINK_CONNECT;
        end
        if (emit && nocar)
        begin
            link_next = mrlp_pkg::LINK_LISTEN;
        end
    end

    // result word
    always_comb
    begin
        res.line_length = 6'(len);
        res.accept_call = ring;
        res.call_ended  = nocar;
        res.time_valid  = tv;
        res.hours       = tv ? mod24(hh_raw) : 5'd0;
        res.minutes     = tv ? mod60(mm_raw) : 6'd0;
        res.link_state  = link_next;
    end

endmodule

@@ rtl/modem_response_line_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modem_response_line_parser
// Splits received modem bytes into lines and reports RING, NO CARRIER and
// star-time settings for every line that is not a bare terminator.
//
//   channel  dir  payload                                   word
//   rx       in   rx_byte                                   one received byte
//   res      out  line_length accept_call call_ended        one line report
//                 time_valid hours minutes link_state
//
// One byte is taken per cycle when the report side keeps up.
// A byte is registered in the entry register, decoded from there, and its report,
// if any, is registered in the output register when the entry register moves on.
// A stalled report holds the pipe: rx stays ready while the entry register
// is free or moves on in the same cycle.
// Reset clears the line state and sets the link state to listening.
// ----------------------------------------------------------------------------
`include "modem_response_line_parser_macros.svh"

module modem_response_line_parser (
    input logic         clk,
    input logic         rst_n,
    mrlp_rx_if.sink     rx,
    mrlp_res_if.source  res
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              advance;
    mrlp_pkg::line_t   fin_line;
    logic              close;
    logic              emit;
    mrlp_pkg::link_t   link_reg;
    mrlp_pkg::link_t   link_next;
    mrlp_pkg::result_t res_word;
    logic              out_valid_reg;
    mrlp_pkg::result_t out_reg;

    // entry register moves on when the output register can take a report
    assign advance  = in_valid_reg && (!out_valid_reg || res.ready);
    assign rx.ready = !in_valid_reg || advance;

    // entry register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    // line collection
    mrlp_line_track u_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .rx_byte  (in_byte_reg),
        .fin_line (fin_line),
        .close    (close)
    );

    // line decode
    mrlp_line_finish u_finish (
        .fin_line  (fin_line),
        .close     (close),
        .link_cur  (link_reg),
        .emit      (emit),
        .link_next (link_next),
        .res       (res_word)
    );

    // link state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= mrlp_pkg::LINK_LISTEN;
        end
        else if (advance)
        begin
            link_reg <= link_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_reg <= res_word;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.line_length = out_reg.line_length;
    assign res.accept_call = out_reg.accept_call;
    assign res.call_ended  = out_reg.call_ended;
    assign res.time_valid  = out_reg.time_valid;
    assign res.hours       = out_reg.hours;
    assign res.minutes     = out_reg.minutes;
    assign res.link_state  = out_reg.link_state;

    // checks
    `MRLP_ASSERT_NEXT(a_report_link, advance && emit, res.valid && res.link_state == link_reg)
    `MRLP_ASSERT_NOW(a_prefix_excl, res.valid, !(res.accept_call && res.call_ended))
    `MRLP_ASSERT_NOW(a_time_zero, res.valid && !res.time_valid, res.hours == 5'd0 && res.minutes == 6'd0)
    `MRLP_ASSERT_NOW(a_time_range, res.valid, res.hours < 5'd24 && res.minutes < 6'd60)
    `MRLP_ASSERT_NOW(a_stall_cause, !rx.ready, in_valid_reg && out_valid_reg && !res.ready)

endmodule
